// ===== hw/rtl/i2cebm_pkg.sv =====
// i2cebm_pkg: shared types and constants for the I2C EEPROM byte master.
// Word structs, sequencer phase codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package i2cebm_pkg;

  localparam int WordAddrBitsDef = 11;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] CFG_PHASE_TICKS = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_WRITE_CYCLE = 2'd2;

  localparam logic [9:0]  PHASE_TICKS_RST = 10'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd200;
  localparam logic [23:0] WRITE_CYCLE_RST = 24'd3000;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [7:0] CTRL_READ_BIT = 8'h01;
  localparam logic [7:0] CTRL_BASE_MSK = 8'hFE;

  // byte on the bus
  localparam logic [1:0] STG_CTRL  = 2'd0;
  localparam logic [1:0] STG_ADDR  = 2'd1;
  localparam logic [1:0] STG_DATA  = 2'd2;
  localparam logic [1:0] STG_RCTRL = 2'd3;

  typedef enum logic [16:0] {
    PH_IDLE      = 17'h00001,
    PH_START_A   = 17'h00002,
    PH_START_B   = 17'h00004,
    PH_BIT_LOW   = 17'h00008,
    PH_BIT_HIGH  = 17'h00010,
    PH_ACK_LOW   = 17'h00020,
    PH_ACK_WAIT  = 17'h00040,
    PH_ACK_END   = 17'h00080,
    PH_READ_LOW  = 17'h00100,
    PH_READ_HIGH = 17'h00200,
    PH_NACK_LOW  = 17'h00400,
    PH_NACK_HIGH = 17'h00800,
    PH_STOP_A    = 17'h01000,
    PH_STOP_B    = 17'h02000,
    PH_STOP_C    = 17'h04000,
    PH_STOP_D    = 17'h08000,
    PH_WAIT      = 17'h10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  device_address;
    logic [10:0] word_address;
    logic [7:0]  write_data;
    logic        sda_level;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } out_word_t;

endpackage

// ===== hw/rtl/i2cebm_core.sv =====
// i2cebm_core: bus sequencer state, configuration registers and the
// single-pass next-state logic applied to each accepted word.
// Depends on i2cebm_pkg.
`timescale 1ns / 1ps

module i2cebm_core import i2cebm_pkg::*; #(
  parameter int WORD_ADDR_BITS = WordAddrBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        acc,
  input  in_word_t    in_word,
  output out_word_t   res_word
);

  localparam logic [2:0] BLK_MASK = 3'((1 << (WORD_ADDR_BITS - 8)) - 1);

  logic [9:0]  phase_ticks_r;
  logic [7:0]  ack_timeout_r;
  logic [23:0] write_cycle_r;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  stage_r, stage_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [9:0]  div_r, div_nxt;
  logic [7:0]  ack_cnt_r, ack_cnt_nxt;
  logic [23:0] wait_cnt_r, wait_cnt_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        is_read_r, is_read_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        err_r, err_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_low_r, sda_low_nxt;
  logic        done;

  logic        do_load;
  logic [7:0]  load_val;
  logic        interval_hit;
  logic [2:0]  blk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
      write_cycle_r <= WRITE_CYCLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_TICKS: phase_ticks_r <= cfg_data[9:0];
        CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_data[7:0];
        CFG_WRITE_CYCLE: write_cycle_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign interval_hit = ({1'b0, div_r} + 11'd1) >= {1'b0, phase_ticks_r};
  assign blk          = in_word.word_address[10:8] & BLK_MASK;

  always_comb begin
    phase_nxt    = phase_r;
    stage_nxt    = stage_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    div_nxt      = div_r;
    ack_cnt_nxt  = ack_cnt_r;
    wait_cnt_nxt = wait_cnt_r;
    ctrl_nxt     = ctrl_r;
    addr_nxt     = addr_r;
    data_nxt     = data_r;
    is_read_nxt  = is_read_r;
    rx_nxt       = rx_r;
    err_nxt      = err_r;
    scl_nxt      = scl_r;
    sda_low_nxt  = sda_low_r;
    done         = 1'b0;
    do_load      = 1'b0;
    load_val     = 8'h00;

    if (acc) begin
      case (in_word.mode) inside
        MODE_TICK: begin
          unique case (phase_r)
            PH_IDLE: ;
            PH_WAIT: begin
              if (wait_cnt_r <= 24'd1) begin
                wait_cnt_nxt = 24'd0;
                phase_nxt    = PH_IDLE;
              end else begin
                wait_cnt_nxt = wait_cnt_r - 24'd1;
              end
            end
            PH_ACK_WAIT: begin
              if (!in_word.sda_level) begin
                scl_nxt   = 1'b0;
                div_nxt   = 10'd0;
                phase_nxt = PH_ACK_END;
              end else if (ack_cnt_r >= ack_timeout_r) begin
                err_nxt   = 1'b1;
                div_nxt   = 10'd0;
                scl_nxt   = 1'b0;
                phase_nxt = PH_STOP_A;
              end else begin
                ack_cnt_nxt = ack_cnt_r + 8'd1;
              end
            end
            PH_READ_HIGH: begin
              if (interval_hit) begin
                div_nxt     = 10'd0;
                shift_nxt   = {shift_r[6:0], in_word.sda_level};
                scl_nxt     = 1'b0;
                bit_cnt_nxt = bit_cnt_r + 4'd1;
                phase_nxt   = (bit_cnt_nxt >= BITS_PER_BYTE) ? PH_NACK_LOW : PH_READ_LOW;
              end else begin
                div_nxt = div_r + 10'd1;
              end
            end
            default: begin
              if (!interval_hit) begin
                div_nxt = div_r + 10'd1;
              end else begin
                div_nxt = 10'd0;
                unique case (phase_r)
                  PH_START_A: begin
                    sda_low_nxt = 1'b1;
                    phase_nxt   = PH_START_B;
                  end
                  PH_START_B: begin
                    do_load  = 1'b1;
                    load_val = (stage_r == STG_RCTRL) ? (ctrl_r | CTRL_READ_BIT) : ctrl_r;
                  end
                  PH_BIT_LOW: begin
                    scl_nxt   = 1'b1;
                    phase_nxt = PH_BIT_HIGH;
                  end
                  PH_BIT_HIGH: begin
                    scl_nxt     = 1'b0;
                    shift_nxt   = {shift_r[6:0], 1'b0};
                    bit_cnt_nxt = bit_cnt_r + 4'd1;
                    if (bit_cnt_nxt >= BITS_PER_BYTE) begin
                      sda_low_nxt = 1'b0;
                      phase_nxt   = PH_ACK_LOW;
                    end else begin
                      sda_low_nxt = ~shift_nxt[7];
                      phase_nxt   = PH_BIT_LOW;
                    end
                  end
                  PH_ACK_LOW: begin
                    scl_nxt     = 1'b1;
                    ack_cnt_nxt = 8'd0;
                    phase_nxt   = PH_ACK_WAIT;
                  end
                  PH_ACK_END: begin
                    unique case (stage_r)
                      STG_CTRL: begin
                        stage_nxt = STG_ADDR;
                        do_load   = 1'b1;
                        load_val  = addr_r;
                      end
                      STG_ADDR: begin
                        if (is_read_r) begin
                          stage_nxt   = STG_RCTRL;
                          scl_nxt     = 1'b1;
                          sda_low_nxt = 1'b0;
                          phase_nxt   = PH_START_A;
                        end else begin
                          stage_nxt = STG_DATA;
                          do_load   = 1'b1;
                          load_val  = data_r;
                        end
                      end
                      STG_DATA: begin
                        scl_nxt   = 1'b0;
                        phase_nxt = PH_STOP_A;
                      end
                      default: begin
                        scl_nxt     = 1'b1;
                        bit_cnt_nxt = 4'd0;
                        shift_nxt   = 8'h00;
                        phase_nxt   = PH_READ_HIGH;
                      end
                    endcase
                  end
                  PH_READ_LOW: begin
                    scl_nxt   = 1'b1;
                    phase_nxt = PH_READ_HIGH;
                  end
                  PH_NACK_LOW: begin
                    scl_nxt   = 1'b1;
                    phase_nxt = PH_NACK_HIGH;
                  end
                  PH_NACK_HIGH: begin
                    rx_nxt    = shift_r;
                    scl_nxt   = 1'b0;
                    phase_nxt = PH_STOP_A;
                  end
                  PH_STOP_A: begin
                    sda_low_nxt = 1'b1;
                    phase_nxt   = PH_STOP_B;
                  end
                  PH_STOP_B: begin
                    scl_nxt   = 1'b1;
                    phase_nxt = PH_STOP_C;
                  end
                  PH_STOP_C: begin
                    sda_low_nxt = 1'b0;
                    phase_nxt   = PH_STOP_D;
                  end
                  PH_STOP_D: begin
                    done = 1'b1;
                    if (!is_read_r && !err_r && (write_cycle_r != 24'd0)) begin
                      wait_cnt_nxt = write_cycle_r;
                      phase_nxt    = PH_WAIT;
                    end else begin
                      phase_nxt = PH_IDLE;
                    end
                  end
                  default: phase_nxt = PH_IDLE;
                endcase
              end
            end
          endcase
        end
        MODE_WRITE, MODE_READ: begin
          if (phase_r == PH_IDLE) begin
            ctrl_nxt    = (in_word.device_address & CTRL_BASE_MSK) | {4'd0, blk, 1'b0};
            addr_nxt    = in_word.word_address[7:0];
            data_nxt    = in_word.write_data;
            is_read_nxt = (in_word.mode == MODE_READ);
            err_nxt     = 1'b0;
            stage_nxt   = STG_CTRL;
            bit_cnt_nxt = 4'd0;
            ack_cnt_nxt = 8'd0;
            div_nxt     = 10'd0;
            scl_nxt     = 1'b1;
            sda_low_nxt = 1'b0;
            phase_nxt   = PH_START_A;
          end
        end
        default: ;
      endcase

      if (do_load) begin
        shift_nxt   = load_val;
        bit_cnt_nxt = 4'd0;
        scl_nxt     = 1'b0;
        sda_low_nxt = ~load_val[7];
        phase_nxt   = PH_BIT_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      stage_r    <= STG_CTRL;
      bit_cnt_r  <= 4'd0;
      shift_r    <= 8'h00;
      div_r      <= 10'd0;
      ack_cnt_r  <= 8'd0;
      wait_cnt_r <= 24'd0;
      ctrl_r     <= 8'h00;
      addr_r     <= 8'h00;
      data_r     <= 8'h00;
      is_read_r  <= 1'b0;
      rx_r       <= 8'h00;
      err_r      <= 1'b0;
      scl_r      <= 1'b1;
      sda_low_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      stage_r    <= stage_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      div_r      <= div_nxt;
      ack_cnt_r  <= ack_cnt_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      ctrl_r     <= ctrl_nxt;
      addr_r     <= addr_nxt;
      data_r     <= data_nxt;
      is_read_r  <= is_read_nxt;
      rx_r       <= rx_nxt;
      err_r      <= err_nxt;
      scl_r      <= scl_nxt;
      sda_low_r  <= sda_low_nxt;
    end
  end

  assign res_word.scl_level    = scl_nxt;
  assign res_word.sda_pull_low = sda_low_nxt;
  assign res_word.busy_res     = (phase_nxt != PH_IDLE);
  assign res_word.done_res     = done;
  assign res_word.read_data    = rx_nxt;
  assign res_word.ack_error    = err_nxt;

endmodule

// ===== hw/rtl/i2cebm_out_buf.sv =====
// i2cebm_out_buf: two-entry result buffer (output register plus skid)
// between the sequencer and the result channel.
// Depends on i2cebm_pkg.
`timescale 1ns / 1ps

module i2cebm_out_buf import i2cebm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_word_t push_word,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_word_t main_r, main_nxt;
  out_word_t skid_r, skid_nxt;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || !out_stall) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = push_word;
        main_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = push_word;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_word  = main_r;

endmodule

// ===== hw/rtl/i2c_eeprom_byte_master_unit.sv =====
// i2c_eeprom_byte_master_unit: top level of the I2C EEPROM byte master.
// Instantiates i2cebm_core and i2cebm_out_buf; depends on i2cebm_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall/in_word): one word per step. Mode tick
//   advances the bus sequencer by one tick and carries the sampled SDA; mode
//   write or read starts a transaction when idle and is ignored when busy.
//   Result channel (out_valid/out_stall/out_word): exactly one word per
//   accepted input word, giving SCL/SDA drive, busy, done, read data, error.
//   Config port (cfg_we/cfg_index/cfg_data): index 0 phase_ticks, 1
//   ack_timeout, 2 write_cycle_ticks; write only while idle.
//   Results are registered: each shows on out_word from the buffer's output
//   register. Throughput: one word per cycle while in_stall is low; the
//   sequencer updates in the accepting cycle with single-pass logic.
//   Stall: a two-entry result buffer keeps taking input while one result
//   waits; in_stall rises only when both entries are full.
//   Reset (rst_n, synchronous): bus released (SCL high, SDA released),
//   sequencer idle, buffer empty, config registers to their defaults.
`timescale 1ns / 1ps

module i2c_eeprom_byte_master_unit import i2cebm_pkg::*; #(
  parameter int WORD_ADDR_BITS = WordAddrBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic      acc;
  out_word_t res_word;

  assign acc = in_valid && !in_stall;

  i2cebm_core #(
    .WORD_ADDR_BITS(WORD_ADDR_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .acc      (acc),
    .in_word  (in_word),
    .res_word (res_word)
  );

  i2cebm_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc),
    .push_word(res_word),
    .full     (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule
